// File: hdl/energy_vad_attack_release_core_macros.svh
// assertion helpers used by evad_ctrl
`ifndef ENERGY_VAD_ATTACK_RELEASE_CORE_MACROS_SVH
`define ENERGY_VAD_ATTACK_RELEASE_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define EVAD_ASSERT_IMPL(label, clk_s, rst_s, pre, post, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define EVAD_ASSERT_NEXT(label, clk_s, rst_s, pre, post, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: hdl/evad_pkg.sv
package evad_pkg;

	// field widths
	localparam int SAMPLE_W   = 16;
	localparam int SQ_W       = 31;
	localparam int QUO_W      = 31;
	localparam int RMS_W      = 16;
	localparam int LEN_W      = 13;
	localparam int RUN_W      = 24;
	localparam int THR_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// default chunk limit in samples
	localparam int MAX_CHUNK_DEF = 4096;

	// register reset values
	localparam logic [THR_W-1:0] THR_RESET     = 16'd328;
	localparam logic [RUN_W-1:0] ATTACK_RESET  = 24'd1600;
	localparam logic [RUN_W-1:0] RELEASE_RESET = 24'd4800;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 2'd2;

endpackage

// File: hdl/evad_in_if.sv
interface evad_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [evad_pkg::SAMPLE_W-1:0] sample;
	logic                                chunk_end;

	modport source (output valid, output sample, output chunk_end, input ready);
	modport sink (input valid, input sample, input chunk_end, output ready);
endinterface

// File: hdl/evad_out_if.sv
interface evad_out_if;
	logic                         valid;
	logic                         ready;
	logic                         is_speech;
	logic [evad_pkg::RMS_W-1:0] rms_level;
	logic [evad_pkg::LEN_W-1:0] chunk_length;

	modport source (output valid, output is_speech, output rms_level, output chunk_length,
		input ready);
	modport sink (input valid, input is_speech, input rms_level, input chunk_length,
		output ready);
endinterface

// File: hdl/evad_subu.sv
module evad_subu #(
	parameter int W = evad_pkg::QUO_W
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         ge,
	output logic [W-1:0] diff
);

	logic [W:0] wide;

	// one subtractor serves compare and restore steps
	assign wide = {1'b0, a} - {1'b0, b};
	assign ge   = !wide[W];
	assign diff = wide[W-1:0];

endmodule

// File: hdl/evad_acc.sv
module evad_acc #(
	parameter int MAX_CHUNK = evad_pkg::MAX_CHUNK_DEF,
	localparam int CNT_W = $clog2(MAX_CHUNK + 1),
	localparam int SUM_W = evad_pkg::SQ_W - 1 + CNT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	evad_in_if.sink          in_ch,
	input  logic             busy,
	output logic             start,
	output logic [SUM_W-1:0] sum_tot,
	output logic [CNT_W-1:0] cnt_tot
);

	logic [SUM_W-1:0]                     sum_q;
	logic [CNT_W-1:0]                     cnt_q;
	logic signed [2*evad_pkg::SAMPLE_W-1:0] sq_full;
	logic                                 take;
	logic                                 room;

	assign in_ch.ready = !busy;
	assign take        = in_ch.valid && in_ch.ready;
	assign room        = cnt_q < CNT_W'(MAX_CHUNK);

	// square and add, samples past the chunk limit are dropped
	assign sq_full = in_ch.sample * in_ch.sample;
	assign sum_tot = room ? sum_q + SUM_W'(sq_full[evad_pkg::SQ_W-1:0]) : sum_q;
	assign cnt_tot = room ? cnt_q + CNT_W'(1) : cnt_q;
	assign start   = take && in_ch.chunk_end;

	// running sum, cleared when a chunk closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (take) begin
			if (in_ch.chunk_end) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_tot;
				cnt_q <= cnt_tot;
			end
		end
	end

endmodule

// File: hdl/evad_ctrl.sv
`include "energy_vad_attack_release_core_macros.svh"

module evad_ctrl #(
	parameter int MAX_CHUNK = evad_pkg::MAX_CHUNK_DEF,
	localparam int CNT_W  = $clog2(MAX_CHUNK + 1),
	localparam int SUM_W  = evad_pkg::SQ_W - 1 + CNT_W,
	localparam int STEP_W = $clog2(SUM_W + 1),
	localparam int ALU_A  = (evad_pkg::QUO_W > evad_pkg::RUN_W) ?
		evad_pkg::QUO_W : evad_pkg::RUN_W,
	localparam int ALU_W  = (ALU_A > CNT_W + 1) ? ALU_A : CNT_W + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [SUM_W-1:0]             sum_tot,
	input  logic [CNT_W-1:0]             cnt_tot,
	input  logic [evad_pkg::THR_W-1:0]   threshold,
	input  logic [evad_pkg::RUN_W-1:0]   attack_len,
	input  logic [evad_pkg::RUN_W-1:0]   rel_len,
	output logic                         busy,
	evad_out_if.source                   out_ch
);

	localparam int QUO_W = evad_pkg::QUO_W;
	localparam int RUN_W = evad_pkg::RUN_W;
	localparam int RMS_W = evad_pkg::RMS_W;
	localparam int LEN_W = evad_pkg::LEN_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQRT,
		ST_CMP,
		ST_RUN,
		ST_FLAG,
		ST_PUSH
	} state_t;

	state_t             state_q;
	logic [SUM_W-1:0]   num_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   n_q;
	logic [QUO_W-1:0]   quo_q;
	logic [QUO_W-1:0]   res_q;
	logic [QUO_W-1:0]   bit_q;
	logic [STEP_W-1:0]  step_q;
	logic               loud_q;
	logic [RUN_W-1:0]   loud_run_q;
	logic [RUN_W-1:0]   quiet_run_q;
	logic               speech_q;
	logic               out_valid_q;
	logic               out_speech_q;
	logic [RMS_W-1:0]   out_rms_q;
	logic [LEN_W-1:0]   out_len_q;

	logic [ALU_W-1:0]       alu_a;
	logic [ALU_W-1:0]       alu_b;
	logic [ALU_W-1:0]       alu_diff;
	logic                   alu_ge;
	logic [CNT_W:0]         div_a;
	logic [RUN_W:0]         run_sum;
	logic [RUN_W-1:0]       run_sat;
	logic [LEN_W+CNT_W-1:0] len_ext;
	logic                   push;

	assign busy                = state_q != ST_IDLE;
	assign out_ch.valid        = out_valid_q;
	assign out_ch.is_speech    = out_speech_q;
	assign out_ch.rms_level    = out_rms_q;
	assign out_ch.chunk_length = out_len_q;

	// result moves into the output register once it is free
	assign push = (state_q == ST_PUSH) && (!out_valid_q || out_ch.ready);

	// operand select for the shared subtractor
	assign div_a = {rem_q, num_q[SUM_W-1]};
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		unique case (state_q)
			ST_DIV: begin
				alu_a = ALU_W'(div_a);
				alu_b = ALU_W'(n_q);
			end
			ST_SQRT: begin
				alu_a = ALU_W'(quo_q);
				alu_b = ALU_W'(res_q | bit_q);
			end
			ST_CMP: begin
				alu_a = ALU_W'(res_q[RMS_W-1:0]);
				alu_b = ALU_W'(threshold);
			end
			ST_FLAG: begin
				alu_a = loud_q ? ALU_W'(loud_run_q) : ALU_W'(quiet_run_q);
				alu_b = loud_q ? ALU_W'(attack_len) : ALU_W'(rel_len);
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	evad_subu #(
		.W (ALU_W)
	) u_subu (
		.a    (alu_a),
		.b    (alu_b),
		.ge   (alu_ge),
		.diff (alu_diff)
	);

	// saturating run update and length truncation
	assign run_sum = (RUN_W+1)'(loud_q ? loud_run_q : quiet_run_q) + (RUN_W+1)'(n_q);
	assign run_sat = run_sum[RUN_W] ? '1 : run_sum[RUN_W-1:0];
	assign len_ext = (LEN_W+CNT_W)'(n_q);

	// sequencer: divide, root, compare, run update, flag, output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			num_q        <= '0;
			rem_q        <= '0;
			n_q          <= '0;
			quo_q        <= '0;
			res_q        <= '0;
			bit_q        <= '0;
			step_q       <= '0;
			loud_q       <= 1'b0;
			loud_run_q   <= '0;
			quiet_run_q  <= '0;
			speech_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			out_speech_q <= 1'b0;
			out_rms_q    <= '0;
			out_len_q    <= '0;
		end else begin
			// output valid: set on load, cleared after the transfer
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						n_q    <= cnt_tot;
						num_q  <= sum_tot;
						rem_q  <= '0;
						quo_q  <= '0;
						res_q  <= '0;
						bit_q  <= QUO_W'(1) << (QUO_W - 1);
						step_q <= STEP_W'(SUM_W - 1);
						// empty chunk skips the divide, root of zero is zero
						state_q <= (cnt_tot == '0) ? ST_SQRT : ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= alu_ge ? alu_diff[CNT_W-1:0] : div_a[CNT_W-1:0];
					num_q <= num_q << 1;
					quo_q <= {quo_q[QUO_W-2:0], alu_ge};
					if (step_q == '0) begin
						state_q <= ST_SQRT;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_SQRT: begin
					if (alu_ge) begin
						quo_q <= alu_diff[QUO_W-1:0];
						res_q <= (res_q >> 1) | bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					loud_q  <= alu_ge;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (loud_q) begin
						loud_run_q  <= run_sat;
						quiet_run_q <= '0;
					end else begin
						quiet_run_q <= run_sat;
						loud_run_q  <= '0;
					end
					state_q <= ST_FLAG;
				end
				ST_FLAG: begin
					speech_q <= loud_q ? (speech_q | alu_ge) : (speech_q & !alu_ge);
					state_q  <= ST_PUSH;
				end
				ST_PUSH: begin
					if (push) begin
						out_speech_q <= speech_q;
						out_rms_q    <= res_q[RMS_W-1:0];
						out_len_q    <= len_ext[LEN_W-1:0];
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	`EVAD_ASSERT_IMPL(a_start_idle, clk, arst_n, start, state_q == ST_IDLE,
		"chunk closed while sequencer busy")
	`EVAD_ASSERT_IMPL(a_runs_excl, clk, arst_n, 1'b1,
		(loud_run_q == '0) || (quiet_run_q == '0), "loud and quiet runs both nonzero")
	`EVAD_ASSERT_IMPL(a_rem_below_n, clk, arst_n, state_q == ST_DIV, rem_q < n_q,
		"divide remainder not below divisor")
	`EVAD_ASSERT_IMPL(a_rms_bound, clk, arst_n, state_q == ST_CMP,
		res_q <= (QUO_W'(1) << (RMS_W - 1)), "root exceeds full scale")
	`EVAD_ASSERT_NEXT(a_push_out, clk, arst_n, push,
		out_valid_q && (state_q == ST_IDLE), "result not loaded into output register")

endmodule

// File: hdl/energy_vad_attack_release_core.sv
// a sample without chunk_end only adds to the sums; samples stream back to back while idle
// a chunk_end sample runs the divide, the root, then the compare, run update, flag and
// output states; divide, root, compare and flag share one subtractor; the result is
// loaded into the output register as the sequencer returns to idle, input ready again
// a full output register holds the sequencer and the input until its transfer
// async reset clears sums, runs and speech flag; registers go to 328, 1600, 4800
module energy_vad_attack_release_core #(
	parameter int MAX_CHUNK = evad_pkg::MAX_CHUNK_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	evad_in_if.sink                          in_ch,
	evad_out_if.source                       out_ch,
	input  logic                             cfg_wr_en,
	input  logic [evad_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [evad_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CNT_W = $clog2(MAX_CHUNK + 1);
	localparam int SUM_W = evad_pkg::SQ_W - 1 + CNT_W;

	logic [evad_pkg::THR_W-1:0] threshold_q;
	logic [evad_pkg::RUN_W-1:0] attack_q;
	logic [evad_pkg::RUN_W-1:0] rel_q;

	logic             busy;
	logic             start;
	logic [SUM_W-1:0] sum_tot;
	logic [CNT_W-1:0] cnt_tot;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= evad_pkg::THR_RESET;
			attack_q    <= evad_pkg::ATTACK_RESET;
			rel_q       <= evad_pkg::RELEASE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				evad_pkg::REG_THRESHOLD: threshold_q <= cfg_data[evad_pkg::THR_W-1:0];
				evad_pkg::REG_ATTACK:    attack_q    <= cfg_data[evad_pkg::RUN_W-1:0];
				evad_pkg::REG_RELEASE:   rel_q       <= cfg_data[evad_pkg::RUN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sum of squares per chunk
	evad_acc #(
		.MAX_CHUNK (MAX_CHUNK)
	) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.busy    (busy),
		.start   (start),
		.sum_tot (sum_tot),
		.cnt_tot (cnt_tot)
	);

	// rms, hangover decision and output register
	evad_ctrl #(
		.MAX_CHUNK (MAX_CHUNK)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.sum_tot    (sum_tot),
		.cnt_tot    (cnt_tot),
		.threshold  (threshold_q),
		.attack_len (attack_q),
		.rel_len    (rel_q),
		.busy       (busy),
		.out_ch     (out_ch)
	);

endmodule
